### rtl/core/rdc_pkg.sv
`default_nettype none

package rdc_pkg;

  localparam int BASE_W  = 4;
  localparam int DIGIT_W = 4;

  localparam logic [BASE_W-1:0] BASE_MIN = 4'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 4'd9;

  typedef struct packed {
    logic clr;
    logic conv;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/rdc_cell.sv
`default_nettype none

module rdc_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire rdc_pkg::cell_ctrl_t         ctrl,
  input  wire logic [rdc_pkg::BASE_W-1:0]  base,
  input  wire logic                        carry_in,
  input  wire logic                        vld_in,
  input  wire logic [rdc_pkg::DIGIT_W-1:0] digit_in,
  output logic                             carry,
  output logic                             vld,
  output logic [rdc_pkg::DIGIT_W-1:0]      digit
);
  import rdc_pkg::*;

  logic [DIGIT_W:0]   dbl;
  logic               ge;
  logic [DIGIT_W-1:0] digit_next;

  // digit*2 + carry, folded back below the base
  always_comb begin
    dbl        = {digit, carry_in};
    ge         = dbl >= {1'b0, base};
    digit_next = ge ? DIGIT_W'(dbl - {1'b0, base}) : dbl[DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry <= 1'b0;
      vld   <= 1'b0;
    end else if (ctrl.clr) begin
      carry <= 1'b0;
      vld   <= 1'b0;
    end else if (ctrl.conv) begin
      carry <= vld_in & ge;
      vld   <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      digit <= '0;
    end else if (ctrl.conv && vld_in) begin
      digit <= digit_next;
    end else if (ctrl.shift) begin
      digit <= digit_in;
    end
  end

endmodule

`default_nettype wire

### rtl/core/radix_digit_conversion.sv
// radix_digit_conversion: converts a non-negative integer to its digits in
// base 2..9 (base below 2 is taken as 2, above 9 as 9).
// Input stream s_*: one transfer per value; s_tdata holds value (low
// VALUE_BITS bits) then the 4-bit base. Output stream m_*: one transfer per
// digit, most significant first; m_tlast marks the least significant digit.
// A zero value gives a single digit 0 with m_tlast set.
// Bits enter a row of DIGIT_SLOTS digit cells MSB first; each cell doubles
// its digit and adds its neighbor's registered carry, and S_CONV runs until
// the row has settled. The row then shifts toward the top cell, one slot
// per cycle unless a digit to send waits on the output, dropping leading
// zeros and sending the rest. The next value is taken once the last digit
// is in the output register. When the receiver holds m_tready low, the row
// stops at the next digit to send, with the pending digit held in the
// output register. Reset returns the block to idle with no output pending.
`default_nettype none

module radix_digit_conversion #(
  parameter int DIGIT_SLOTS = 32,
  parameter int VALUE_BITS  = 31
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // value, base
  input  wire logic [((VALUE_BITS+rdc_pkg::BASE_W+7)/8)*8-1:0] s_tdata,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // digit
  output logic [7:0]                                 m_tdata,
  output logic                                       m_tlast
);
  import rdc_pkg::*;

  localparam int CNT_W  = $clog2(VALUE_BITS + DIGIT_SLOTS);
  localparam int SLOT_W = $clog2(DIGIT_SLOTS);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_t;

  state_t                  state;
  logic [VALUE_BITS-1:0]   value_sr;
  logic [BASE_W-1:0]       base_r;
  logic [BASE_W-1:0]       base_in;
  logic [BASE_W-1:0]       base_c;
  logic [CNT_W-1:0]        cnt;
  logic [SLOT_W-1:0]       slot;
  logic                    ovf;
  logic                    started;

  logic                    accept;
  logic                    feed;
  logic                    load_ok;
  logic                    keep;
  logic                    load;
  logic                    shift_en;
  cell_ctrl_t              ctrl;

  logic [DIGIT_W-1:0]      digit_w [DIGIT_SLOTS];
  logic                    carry_w [DIGIT_SLOTS];
  logic                    vld_w   [DIGIT_SLOTS];

  always_comb begin
    base_in = s_tdata[VALUE_BITS +: BASE_W];
    if (base_in < BASE_MIN) begin
      base_c = BASE_MIN;
    end else if (base_in > BASE_MAX) begin
      base_c = BASE_MAX;
    end else begin
      base_c = base_in;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign feed     = (state == S_CONV) && (cnt < CNT_W'(VALUE_BITS));
  assign load_ok  = !m_tvalid || m_tready;
  assign keep     = started || ovf || (digit_w[DIGIT_SLOTS-1] != '0) || (slot == '0);
  assign load     = (state == S_EMIT) && keep && load_ok;
  assign shift_en = (state == S_EMIT) && (!keep || load_ok);

  assign ctrl.clr   = accept;
  assign ctrl.conv  = (state == S_CONV);
  assign ctrl.shift = shift_en;

  for (genvar i = 0; i < DIGIT_SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_first
      rdc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .base     (base_r),
        .carry_in (value_sr[VALUE_BITS-1]),
        .vld_in   (feed),
        .digit_in ('0),
        .carry    (carry_w[i]),
        .vld      (vld_w[i]),
        .digit    (digit_w[i])
      );
    end else begin : g_next
      rdc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .base     (base_r),
        .carry_in (carry_w[i-1]),
        .vld_in   (vld_w[i-1]),
        .digit_in (digit_w[i-1]),
        .carry    (carry_w[i]),
        .vld      (vld_w[i]),
        .digit    (digit_w[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      slot     <= '0;
      ovf      <= 1'b0;
      started  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            value_sr <= s_tdata[VALUE_BITS-1:0];
            base_r   <= base_c;
            cnt      <= '0;
            ovf      <= 1'b0;
            started  <= 1'b0;
            state    <= S_CONV;
          end
        end
        S_CONV: begin
          value_sr <= {value_sr[VALUE_BITS-2:0], 1'b0};
          // carry out of the top cell: digits beyond the row are dropped
          ovf      <= ovf | carry_w[DIGIT_SLOTS-1];
          cnt      <= cnt + 1'b1;
          if (cnt == CNT_W'(VALUE_BITS + DIGIT_SLOTS - 1)) begin
            slot  <= SLOT_W'(DIGIT_SLOTS - 1);
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load) begin
            m_tdata  <= {{(8-DIGIT_W){1'b0}}, digit_w[DIGIT_SLOTS-1]};
            m_tlast  <= (slot == '0);
            started  <= 1'b1;
          end
          if (shift_en) begin
            slot <= slot - 1'b1;
            if (slot == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
